// ===== src/scan_reply_classifier_defines.svh =====
// Assertion macros shared by the scan reply classifier RTL.
// Each macro checks on the rising edge of clk and is switched off while rst is high.
`ifndef SCAN_REPLY_CLASSIFIER_DEFINES_SVH
`define SCAN_REPLY_CLASSIFIER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/scr_pkg.sv =====
package scr_pkg;

  // Frame geometry.
  localparam int HEAD_LEN = 13;
  localparam int WIN_LEN  = 9;
  localparam int CRC_SPAN = 7;
  localparam int COUNT_W  = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  // Byte positions after which the CRC snapshots are taken.
  localparam logic [COUNT_W-1:0] POS_THREE = 4'd2;
  localparam logic [COUNT_W-1:0] POS_FOUR  = 4'd3;
  localparam logic [COUNT_W-1:0] POS_SEVEN = 4'd6;

  // Frame bytes.
  localparam logic [7:0] SCAN_ADDR = 8'hFF;
  localparam logic [7:0] SCAN_FUNC = 8'h19;
  localparam logic [7:0] PRE_LO    = 8'h55;
  localparam logic [7:0] PRE_HI    = 8'hFF;

  // Modbus CRC-16.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Register reset values.
  localparam logic [7:0] QUERY_LOW_RST  = 8'd1;
  localparam logic [7:0] QUERY_HIGH_RST = 8'd254;

  typedef enum logic [2:0] {
    VERDICT_NONE    = 3'd0,
    VERDICT_ONE     = 3'd1,
    VERDICT_SEVERAL = 3'd2,
    VERDICT_GARBLED = 3'd3,
    VERDICT_MSTP    = 3'd4
  } verdict_t;

  typedef enum logic {
    REG_QUERY_LOW  = 1'b0,
    REG_QUERY_HIGH = 1'b1
  } reg_index_t;

  // Everything the verdict needs from one finished reply.
  typedef struct packed {
    logic [HEAD_LEN-1:0][7:0] head;
    logic [COUNT_W-1:0]       count;
    logic [15:0]              crc3;
    logic [15:0]              crc4;
    logic [15:0]              crc7;
    logic                     preamble;
  } snap_t;

  // One byte through the reflected CRC-16, bit by bit.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // A CRC value carried on through n zero bytes.
  function automatic logic [15:0] crc_zero_run(input logic [15:0] crc_in, input int n);
    logic [15:0] c;
    c = crc_in;
    for (int k = 0; k < n; k++) begin
      c = crc_byte(c, 8'h00);
    end
    return c;
  endfunction

  // The share of one byte in the CRC once steps byte positions, its own included, have
  // passed. The CRC is linear, so a byte's share simply adds to the rest by XOR.
  function automatic logic [15:0] crc_share(input logic [7:0] b,
                                            input logic [COUNT_W-1:0] steps);
    logic [15:0] c;
    c = {8'h00, b};
    for (int k = 0; k < CRC_SPAN; k++) begin
      if (COUNT_W'(k) < steps) begin
        c = crc_byte(c, 8'h00);
      end
    end
    return c;
  endfunction

  // Snapshot values of an empty reply: the initial value through zero bytes only.
  localparam logic [15:0] CRC_PAD_THREE = crc_zero_run(CRC_INIT, int'(POS_THREE) + 1);
  localparam logic [15:0] CRC_PAD_FOUR  = crc_zero_run(CRC_INIT, int'(POS_FOUR) + 1);
  localparam logic [15:0] CRC_PAD_SEVEN = crc_zero_run(CRC_INIT, int'(POS_SEVEN) + 1);

endpackage

// ===== src/scr_pad_stage.sv =====
module scr_pad_stage
  import scr_pkg::*;
(
  input  logic [COUNT_W-1:0] pos,
  input  logic [7:0]         data,
  input  logic [15:0]        crc3_in,
  input  logic [15:0]        crc4_in,
  input  logic [15:0]        crc7_in,
  output logic [15:0]        crc3_out,
  output logic [15:0]        crc4_out,
  output logic [15:0]        crc7_out
);

  // Each snapshot holds the CRC with every byte yet to arrive taken as zero. A byte at
  // position pos adds its share, run through the zero bytes that follow it up to the
  // snapshot; a snapshot whose last position has passed no longer changes.
  always_comb begin
    crc3_out = crc3_in;
    crc4_out = crc4_in;
    crc7_out = crc7_in;
    if (pos <= POS_THREE) begin
      crc3_out = crc3_in ^ crc_share(data, POS_THREE - pos + COUNT_W'(1));
    end
    if (pos <= POS_FOUR) begin
      crc4_out = crc4_in ^ crc_share(data, POS_FOUR - pos + COUNT_W'(1));
    end
    if (pos <= POS_SEVEN) begin
      crc7_out = crc7_in ^ crc_share(data, POS_SEVEN - pos + COUNT_W'(1));
    end
  end

endmodule

// ===== src/scr_judge.sv =====
module scr_judge
  import scr_pkg::*;
(
  input  snap_t       snap,
  input  logic [7:0]  query_low,
  input  logic [7:0]  query_high,
  output verdict_t    verdict,
  output logic [7:0]  device_id
);

  function automatic logic crc_at(input logic [7:0] lo_b, input logic [7:0] hi_b,
                                  input logic [15:0] crc);
    return (lo_b == crc[7:0]) && (hi_b == crc[15:8]);
  endfunction

  logic one_id;
  logic hdr_ok;
  logic zero_head;
  logic zero_mid;
  logic zero_tail;
  logic zero_lead;
  logic nz_five_six;
  logic clean5;
  logic clean9;
  logic is_echo;
  logic in_range;

  // Checks on the stored head of the reply.
  always_comb begin
    one_id      = (query_low == query_high);
    hdr_ok      = (snap.head[0] == SCAN_ADDR) && (snap.head[1] == SCAN_FUNC);
    zero_lead   = (snap.head[4:0] == '0);
    zero_mid    = (snap.head[HEAD_LEN-1:7] == '0);
    zero_tail   = (snap.head[HEAD_LEN-1:9] == '0);
    zero_head   = zero_lead;
    nz_five_six = (snap.head[5] != 8'h00) || (snap.head[6] != 8'h00);
    clean5      = hdr_ok && crc_at(snap.head[3], snap.head[4], snap.crc3);
    clean9      = hdr_ok && crc_at(snap.head[7], snap.head[8], snap.crc7);
    is_echo     = hdr_ok && (snap.head[2] == query_high) && (snap.head[3] == query_low) &&
                  crc_at(snap.head[4], snap.head[5], snap.crc4);
    in_range    = (snap.head[2] >= query_low) && (snap.head[2] <= query_high);
  end

  // The checks are ordered: the first that fires decides.
  always_comb begin
    device_id = 8'h00;
    priority if (snap.preamble) begin
      verdict = VERDICT_MSTP;
    end else if (snap.count > COUNT_W'(HEAD_LEN)) begin
      verdict = VERDICT_SEVERAL;
    end else if (zero_mid && zero_head) begin
      verdict = VERDICT_NONE;
    end else if (zero_mid && is_echo) begin
      verdict = VERDICT_NONE;
    end else if (zero_mid && nz_five_six) begin
      verdict = (one_id && clean5) ? VERDICT_GARBLED : VERDICT_SEVERAL;
    end else if (zero_mid && !clean5) begin
      verdict = VERDICT_GARBLED;
    end else if (!zero_mid && !zero_tail) begin
      verdict = (one_id && clean9) ? VERDICT_GARBLED : VERDICT_SEVERAL;
    end else if (!zero_mid && !clean9) begin
      verdict = VERDICT_GARBLED;
    end else if (!in_range) begin
      verdict = VERDICT_GARBLED;
    end else begin
      verdict   = VERDICT_ONE;
      device_id = snap.head[2];
    end
  end

endmodule

// ===== src/scan_reply_classifier.sv =====
// A reply's ending item is held in the input register, then its verdict in the result register.
// Throughput: one item per cycle while the result is not stalled; the byte is taken and
// the verdict formed in one pass between the input register and the result register.
// A stalled result holds the input register and the reply state, so the input stalls too.
// Reset (synchronous, active high) empties both registers, clears the reply state and sets
// query_low to 1 and query_high to 254.
module scan_reply_classifier
  import scr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       end_of_reply,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] verdict,
  output logic [7:0] device_id,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

`include "scan_reply_classifier_defines.svh"

  logic adv;
  logic end_take;
  logic byte_take;

  // Configuration registers.
  logic [7:0] query_low;
  logic [7:0] query_high;

  // Input register.
  logic       s0_valid;
  logic [7:0] s0_data;
  logic       s0_has;
  logic       s0_end;

  // Reply state; the CRC snapshots count bytes not yet seen as zero.
  logic [HEAD_LEN-1:0][7:0] head_bytes, head_bytes_next;
  logic [WIN_LEN-1:0][7:0]  recent_bytes, recent_bytes_next;
  logic [COUNT_W-1:0]       bytes_seen, bytes_seen_next;
  logic [15:0]              crc_after_three, crc_after_three_next;
  logic [15:0]              crc_after_four, crc_after_four_next;
  logic [15:0]              crc_after_seven, crc_after_seven_next;
  logic                     preamble_seen, preamble_seen_next;

  logic [15:0] pad3;
  logic [15:0] pad4;
  logic [15:0] pad7;

  snap_t      judge_snap;
  verdict_t   judge_verdict;
  logic [7:0] judge_id;

  // Everything moves unless a result is waiting and stalled.
  assign adv       = !out_valid || !out_stall;
  assign in_stall  = !adv;
  assign cfg_ready = 1'b1;
  assign end_take  = adv && s0_valid && s0_end;
  assign byte_take = adv && s0_valid && !s0_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_low  <= QUERY_LOW_RST;
      query_high <= QUERY_HIGH_RST;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_QUERY_LOW:  query_low  <= cfg_data;
        REG_QUERY_HIGH: query_high <= cfg_data;
        default:        query_low  <= query_low;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_data <= data_byte;
      s0_has  <= has_byte;
      s0_end  <= end_of_reply;
    end
  end

  // The byte's share in each CRC snapshot.
  scr_pad_stage u_pad (
    .pos      (bytes_seen),
    .data     (s0_data),
    .crc3_in  (crc_after_three),
    .crc4_in  (crc_after_four),
    .crc7_in  (crc_after_seven),
    .crc3_out (pad3),
    .crc4_out (pad4),
    .crc7_out (pad7)
  );

  // Take one byte: preamble window, head store, CRC snapshots and count.
  always_comb begin
    head_bytes_next      = head_bytes;
    recent_bytes_next    = recent_bytes;
    bytes_seen_next      = bytes_seen;
    crc_after_three_next = crc_after_three;
    crc_after_four_next  = crc_after_four;
    crc_after_seven_next = crc_after_seven;
    preamble_seen_next   = preamble_seen;
    if (s0_has) begin
      if ((recent_bytes[0] == PRE_LO) && (recent_bytes[1] == PRE_HI) &&
          (recent_bytes[WIN_LEN-1] == PRE_LO) && (s0_data == PRE_HI)) begin
        preamble_seen_next = 1'b1;
      end
      recent_bytes_next = {s0_data, recent_bytes[WIN_LEN-1:1]};
      if (bytes_seen < COUNT_W'(HEAD_LEN)) begin
        head_bytes_next[bytes_seen] = s0_data;
      end
      crc_after_three_next = pad3;
      crc_after_four_next  = pad4;
      crc_after_seven_next = pad7;
      if (bytes_seen != COUNT_MAX) begin
        bytes_seen_next = bytes_seen + COUNT_W'(1);
      end
    end
  end

  // State register; an ending item is judged and clears the state.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_bytes      <= '0;
      recent_bytes    <= '0;
      bytes_seen      <= '0;
      crc_after_three <= CRC_PAD_THREE;
      crc_after_four  <= CRC_PAD_FOUR;
      crc_after_seven <= CRC_PAD_SEVEN;
      preamble_seen   <= 1'b0;
    end else if (adv && s0_valid) begin
      if (s0_end) begin
        head_bytes      <= '0;
        recent_bytes    <= '0;
        bytes_seen      <= '0;
        crc_after_three <= CRC_PAD_THREE;
        crc_after_four  <= CRC_PAD_FOUR;
        crc_after_seven <= CRC_PAD_SEVEN;
        preamble_seen   <= 1'b0;
      end else begin
        head_bytes      <= head_bytes_next;
        recent_bytes    <= recent_bytes_next;
        bytes_seen      <= bytes_seen_next;
        crc_after_three <= crc_after_three_next;
        crc_after_four  <= crc_after_four_next;
        crc_after_seven <= crc_after_seven_next;
        preamble_seen   <= preamble_seen_next;
      end
    end
  end

  // The reply as it stands once the current byte has been taken.
  always_comb begin
    judge_snap.head     = head_bytes_next;
    judge_snap.count    = bytes_seen_next;
    judge_snap.crc3     = crc_after_three_next;
    judge_snap.crc4     = crc_after_four_next;
    judge_snap.crc7     = crc_after_seven_next;
    judge_snap.preamble = preamble_seen_next;
  end

  scr_judge u_judge (
    .snap       (judge_snap),
    .query_low  (query_low),
    .query_high (query_high),
    .verdict    (judge_verdict),
    .device_id  (judge_id)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s0_valid && s0_end;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      verdict   <= judge_verdict;
      device_id <= judge_id;
    end
  end

  `SCR_ASSERT_IMPL(a_id_only_one, out_valid && |device_id, verdict == VERDICT_ONE, "stray id")
  `SCR_ASSERT_NEXT(a_clear_after_end, end_take, bytes_seen == '0, "count not cleared")
  `SCR_ASSERT_NEXT(a_count_grows, byte_take, bytes_seen >= $past(bytes_seen), "count fell")
  `SCR_ASSERT_IMPL(a_take_when_empty, !out_valid, !in_stall, "input stalled while empty")

endmodule
